FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle, outside reset
`define AP_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("%m: implication failed");

// a implies b in the next cycle, outside reset
`define AP_NEXT_RST(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("%m: next-cycle check failed");

// a implies b in the next cycle, reset included
`define AP_NEXT(lbl, clk, a, b) \
    lbl: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: src/tppf_pkg.sv
package tppf_pkg;

    localparam int PT_W       = 32;   // point coordinate
    localparam int DF_W       = 33;   // edge vector component
    localparam int PR_W       = 66;   // cross product term
    localparam int NV_W       = 67;   // normal component
    localparam int LEN_W      = 7;
    localparam int SH_W       = 6;
    localparam int NORM_BITS  = 30;
    localparam int SQ_W       = 60;   // square of a normalized component
    localparam int S_W        = 62;   // sum of squares
    localparam int Q_W        = 49;   // quotient of 2^48 * x^2 / s
    localparam int K_W        = 25;   // unit magnitude, 24 fraction bits
    localparam int CF_W       = 17;
    localparam int AB_W       = 18;
    localparam int UV_W       = 26;   // signed unit value
    localparam int UP_W       = 58;
    localparam int DSUM_W     = 60;
    localparam int UNIT_SH    = 24;
    localparam int COEF_DROP  = 8;
    localparam int SMALL_W    = 13;
    localparam int SMSQ_W     = 26;
    localparam int SMALL_MAG  = 4295;
    localparam int LEN_SQ_LIMIT = 18446744;

    localparam int DIV_STEPS  = 49;
    localparam int SQRT_STEPS = 25;
    localparam int LANE_STG   = DIV_STEPS + SQRT_STEPS;

    // stage numbers
    localparam int ST_DIFF    = 0;
    localparam int ST_MUL     = 1;
    localparam int ST_NRM     = 2;
    localparam int ST_MAG     = 3;
    localparam int ST_LEN     = 4;
    localparam int ST_SHIFT   = 5;
    localparam int ST_SQ      = 6;
    localparam int ST_SSUM    = 7;
    localparam int ST_LANE0   = 8;
    localparam int ST_PROD    = ST_LANE0 + LANE_STG;
    localparam int ST_DSUM    = ST_PROD + 1;
    localparam int ST_OUT     = ST_DSUM + 1;
    localparam int N_STG      = ST_OUT + 1;

    typedef struct packed {
        logic                    tag;
        logic signed [PT_W-1:0]  px;
        logic signed [PT_W-1:0]  py;
        logic signed [PT_W-1:0]  pz;
        logic [2:0]              neg;
        logic                    degen;
    } t_side;

endpackage

FILE: src/tppf_lane.sv
module tppf_lane import tppf_pkg::*; (
    input  logic                i_clk,
    input  logic [LANE_STG-1:0] i_ld,
    input  logic [SQ_W-1:0]     i_xsq,
    input  logic [S_W-1:0]      i_ssum,
    output logic [K_W-1:0]      o_k
);

    logic [S_W-1:0] r_rem [DIV_STEPS];
    logic [S_W-1:0] r_den [DIV_STEPS];
    logic [Q_W-1:0] r_quo [DIV_STEPS];

    logic [Q_W-1:0] r_srem [SQRT_STEPS];
    logic [Q_W:0]   r_sres [SQRT_STEPS];

    // restoring divide, one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [S_W:0]   w_trial;
        logic [S_W-1:0] w_den;
        logic [Q_W-1:0] w_quo;
        logic [S_W:0]   w_diff;
        logic           w_ge;

        if (j == 0) begin : g_first
            assign w_trial = {{(S_W+1-SQ_W){1'b0}}, i_xsq};
            assign w_den   = i_ssum;
            assign w_quo   = '0;
        end else begin : g_next
            assign w_trial = {r_rem[j-1], 1'b0};
            assign w_den   = r_den[j-1];
            assign w_quo   = r_quo[j-1];
        end

        assign w_diff = w_trial - {1'b0, w_den};
        assign w_ge   = w_trial >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (i_ld[j]) begin
                r_den[j] <= w_den;
                r_rem[j] <= w_ge ? w_diff[S_W-1:0] : w_trial[S_W-1:0];
                r_quo[j] <= {w_quo[Q_W-2:0], w_ge};
            end
        end
    end

    // integer square root, one result bit per stage
    for (genvar t = 0; t < SQRT_STEPS; t++) begin : g_sqrt
        localparam int BSH = 2 * (SQRT_STEPS - 1 - t);
        logic [Q_W:0]   w_b;
        logic [Q_W-1:0] w_rem;
        logic [Q_W:0]   w_res;
        logic [Q_W:0]   w_tst;
        logic [Q_W:0]   w_rdiff;
        logic           w_ge;

        assign w_b = (Q_W+1)'(1) << BSH;

        if (t == 0) begin : g_first
            assign w_rem = r_quo[DIV_STEPS-1];
            assign w_res = '0;
        end else begin : g_next
            assign w_rem = r_srem[t-1];
            assign w_res = r_sres[t-1];
        end

        assign w_tst   = w_res + w_b;
        assign w_ge    = {1'b0, w_rem} >= w_tst;
        assign w_rdiff = {1'b0, w_rem} - w_tst;

        always_ff @(posedge i_clk) begin
            if (i_ld[DIV_STEPS+t]) begin
                r_srem[t] <= w_ge ? w_rdiff[Q_W-1:0] : w_rem;
                r_sres[t] <= w_ge ? (w_res >> 1) + w_b : w_res >> 1;
            end
        end
    end

    assign o_k = r_sres[SQRT_STEPS-1][K_W-1:0];

endmodule

FILE: src/three_point_plane_fit_top.sv
// channel | direction | handshake         | payload
// request | in        | i_valid / o_stall | i_is_ceiling, i_p1_x .. i_p3_z
// result  | out       | o_valid / i_stall | o_plane_valid, o_is_ceiling_out, o_coef_a..d
//
// Fully pipelined: one request per cycle while o_stall is low, 85 register stages.
// Most of the depth comes from the divider (49 stages) and square root (25 stages) per axis.
// Synchronous active-low reset clears the stage valid bits only.
// A stall at the output fills bubbles upstream first; input stalls only when
// every stage holds a request.
module three_point_plane_fit_top import tppf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_is_ceiling,
    input  logic signed [PT_W-1:0] i_p1_x,
    input  logic signed [PT_W-1:0] i_p1_y,
    input  logic signed [PT_W-1:0] i_p1_z,
    input  logic signed [PT_W-1:0] i_p2_x,
    input  logic signed [PT_W-1:0] i_p2_y,
    input  logic signed [PT_W-1:0] i_p2_z,
    input  logic signed [PT_W-1:0] i_p3_x,
    input  logic signed [PT_W-1:0] i_p3_y,
    input  logic signed [PT_W-1:0] i_p3_z,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_plane_valid,
    output logic                   o_is_ceiling_out,
    output logic signed [AB_W-1:0] o_coef_a,
    output logic signed [AB_W-1:0] o_coef_b,
    output logic [CF_W-1:0]        o_coef_c,
    output logic signed [PT_W-1:0] o_coef_d
);

    function automatic logic [LEN_W-1:0] bit_len(input logic [NV_W-1:0] x);
        logic [LEN_W-1:0] l;
        l = '0;
        for (int i = 0; i < NV_W; i++) begin
            if (x[i]) begin
                l = LEN_W'(i + 1);
            end
        end
        return l;
    endfunction

    // pipeline control
    logic [N_STG-1:0] r_v;
    logic [N_STG-1:0] w_rdy;
    logic [N_STG-1:0] w_ld;

    always_comb begin
        w_rdy[N_STG-1] = !r_v[N_STG-1] || !i_stall;
        for (int i = N_STG - 2; i >= 0; i--) begin
            w_rdy[i] = !r_v[i] || w_rdy[i+1];
        end
        w_ld[0] = w_rdy[0] && i_valid;
        for (int i = 1; i < N_STG; i++) begin
            w_ld[i] = w_rdy[i] && r_v[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int i = 1; i < N_STG; i++) begin
                if (w_rdy[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_v[N_STG-1];

    // side data: tag, first point, signs, degenerate flag
    t_side r_side [N_STG];
    t_side n_side [N_STG];

    // datapath registers
    logic signed [DF_W-1:0] r_u [3];
    logic signed [DF_W-1:0] r_w [3];
    logic signed [PR_W-1:0] r_prod [6];
    logic signed [NV_W-1:0] r_n [3];
    logic [NV_W-1:0]        r_mag [3];
    logic [NV_W-1:0]        r_mag4 [3];
    logic [SH_W-1:0]        r_shift;
    logic                   r_small;
    logic [SMSQ_W-1:0]      r_smsq [3];
    logic [NORM_BITS-1:0]   r_sh [3];
    logic [SQ_W-1:0]        r_xsq6 [3];
    logic [SQ_W-1:0]        r_xsq7 [3];
    logic [S_W-1:0]         r_ssum;
    logic [K_W-1:0]         w_k [3];
    logic signed [UP_W-1:0] r_up [3];
    logic [CF_W-1:0]        r_cmag82 [3];
    logic                   r_ok82;
    logic [CF_W-1:0]        r_cmag83 [3];
    logic                   r_ok83;
    logic signed [DSUM_W-1:0] r_dsum;
    logic                   r_out_ok;
    logic signed [AB_W-1:0] r_out_a;
    logic signed [AB_W-1:0] r_out_b;
    logic [CF_W-1:0]        r_out_c;
    logic signed [PT_W-1:0] r_out_d;

    logic [NV_W-1:0]        w_mag [3];
    logic [NV_W-1:0]        w_or;
    logic [LEN_W-1:0]       w_len;
    logic [LEN_W-1:0]       w_lsub;
    logic [NV_W-1:0]        w_shd [3];
    logic [SMSQ_W+1:0]      w_smsum;
    logic                   w_degen;
    logic signed [UV_W-1:0] w_uv [3];
    logic [2:0]             w_sgn;
    logic [CF_W-1:0]        w_cmag [3];
    logic signed [DSUM_W-1:0] w_adj;
    logic signed [DSUM_W-1:0] w_q;
    logic signed [DSUM_W-1:0] w_dn;
    logic                   w_ovf;
    logic signed [PT_W-1:0] w_dsat;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_n[i][NV_W-1] ? (~r_n[i] + 1'b1) : r_n[i];
        end
    end

    assign w_or   = r_mag[0] | r_mag[1] | r_mag[2];
    assign w_len  = bit_len(w_or);
    assign w_lsub = w_len - LEN_W'(NORM_BITS);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_shd[i] = r_mag4[i] >> r_shift;
        end
    end

    assign w_smsum = (SMSQ_W+2)'(r_smsq[0]) + (SMSQ_W+2)'(r_smsq[1])
                   + (SMSQ_W+2)'(r_smsq[2]);
    assign w_degen = r_small && (w_smsum <= (SMSQ_W+2)'(LEN_SQ_LIMIT));

    always_comb begin
        n_side[0].tag   = i_is_ceiling;
        n_side[0].px    = i_p1_x;
        n_side[0].py    = i_p1_y;
        n_side[0].pz    = i_p1_z;
        n_side[0].neg   = '0;
        n_side[0].degen = 1'b0;
        for (int i = 1; i < N_STG; i++) begin
            n_side[i] = r_side[i-1];
        end
        n_side[ST_MAG].neg = {r_n[2][NV_W-1], r_n[1][NV_W-1], r_n[0][NV_W-1]};
        n_side[ST_SHIFT].degen = w_degen;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_STG; i++) begin
            if (w_ld[i]) begin
                r_side[i] <= n_side[i];
            end
        end
    end

    // edge vectors
    always_ff @(posedge i_clk) begin
        if (w_ld[ST_DIFF]) begin
            r_u[0] <= $signed({i_p2_x[PT_W-1], i_p2_x}) - $signed({i_p1_x[PT_W-1], i_p1_x});
            r_u[1] <= $signed({i_p2_y[PT_W-1], i_p2_y}) - $signed({i_p1_y[PT_W-1], i_p1_y});
            r_u[2] <= $signed({i_p2_z[PT_W-1], i_p2_z}) - $signed({i_p1_z[PT_W-1], i_p1_z});
            r_w[0] <= $signed({i_p3_x[PT_W-1], i_p3_x}) - $signed({i_p1_x[PT_W-1], i_p1_x});
            r_w[1] <= $signed({i_p3_y[PT_W-1], i_p3_y}) - $signed({i_p1_y[PT_W-1], i_p1_y});
            r_w[2] <= $signed({i_p3_z[PT_W-1], i_p3_z}) - $signed({i_p1_z[PT_W-1], i_p1_z});
        end
    end

    // cross product terms
    always_ff @(posedge i_clk) begin
        if (w_ld[ST_MUL]) begin
            r_prod[0] <= r_u[1] * r_w[2];
            r_prod[1] <= r_u[2] * r_w[1];
            r_prod[2] <= r_u[2] * r_w[0];
            r_prod[3] <= r_u[0] * r_w[2];
            r_prod[4] <= r_u[0] * r_w[1];
            r_prod[5] <= r_u[1] * r_w[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_NRM]) begin
            for (int i = 0; i < 3; i++) begin
                r_n[i] <= $signed({r_prod[2*i][PR_W-1], r_prod[2*i]})
                        - $signed({r_prod[2*i+1][PR_W-1], r_prod[2*i+1]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_MAG]) begin
            r_mag <= w_mag;
        end
    end

    // normalizing shift and small-normal check
    always_ff @(posedge i_clk) begin
        if (w_ld[ST_LEN]) begin
            r_mag4  <= r_mag;
            r_shift <= (w_len > LEN_W'(NORM_BITS)) ? w_lsub[SH_W-1:0] : '0;
            r_small <= (r_mag[0] < NV_W'(SMALL_MAG)) && (r_mag[1] < NV_W'(SMALL_MAG))
                    && (r_mag[2] < NV_W'(SMALL_MAG));
            for (int i = 0; i < 3; i++) begin
                r_smsq[i] <= r_mag[i][SMALL_W-1:0] * r_mag[i][SMALL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_SHIFT]) begin
            for (int i = 0; i < 3; i++) begin
                r_sh[i] <= w_shd[i][NORM_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_SQ]) begin
            for (int i = 0; i < 3; i++) begin
                r_xsq6[i] <= r_sh[i] * r_sh[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_SSUM]) begin
            r_xsq7 <= r_xsq6;
            r_ssum <= S_W'(r_xsq6[0]) + S_W'(r_xsq6[1]) + S_W'(r_xsq6[2]);
        end
    end

    // unit magnitude per axis: floor(sqrt(2^48 * x^2 / s))
    for (genvar g = 0; g < 3; g++) begin : g_lane
        tppf_lane u_lane (
            .i_clk  (i_clk),
            .i_ld   (w_ld[ST_LANE0 +: LANE_STG]),
            .i_xsq  (r_xsq7[g]),
            .i_ssum (r_ssum),
            .o_k    (w_k[g])
        );
    end

    // flip so that z is non-negative
    assign w_sgn = {1'b0,
                    r_side[ST_PROD-1].neg[1] ^ r_side[ST_PROD-1].neg[2],
                    r_side[ST_PROD-1].neg[0] ^ r_side[ST_PROD-1].neg[2]};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_uv[i]   = w_sgn[i] ? -$signed({1'b0, w_k[i]}) : $signed({1'b0, w_k[i]});
            w_cmag[i] = w_k[i][K_W-1:COEF_DROP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_PROD]) begin
            r_up[0]  <= w_uv[0] * r_side[ST_PROD-1].px;
            r_up[1]  <= w_uv[1] * r_side[ST_PROD-1].py;
            r_up[2]  <= w_uv[2] * r_side[ST_PROD-1].pz;
            r_cmag82 <= w_cmag;
            r_ok82   <= !r_side[ST_PROD-1].degen && (w_cmag[2] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_DSUM]) begin
            r_dsum <= $signed({{2{r_up[0][UP_W-1]}}, r_up[0]})
                    + $signed({{2{r_up[1][UP_W-1]}}, r_up[1]})
                    + $signed({{2{r_up[2][UP_W-1]}}, r_up[2]});
            r_cmag83 <= r_cmag82;
            r_ok83   <= r_ok82;
        end
    end

    // d = -trunc(sum / 2^24), saturated
    assign w_adj  = r_dsum + (r_dsum[DSUM_W-1] ? DSUM_W'((1 << UNIT_SH) - 1) : '0);
    assign w_q    = w_adj >>> UNIT_SH;
    assign w_dn   = -w_q;
    assign w_ovf  = (w_dn[DSUM_W-1:PT_W-1] != '0) && (w_dn[DSUM_W-1:PT_W-1] != '1);
    assign w_dsat = w_ovf ? (w_dn[DSUM_W-1] ? {1'b1, {(PT_W-1){1'b0}}}
                                            : {1'b0, {(PT_W-1){1'b1}}})
                          : w_dn[PT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_ld[ST_OUT]) begin
            r_out_ok <= r_ok83;
            if (r_ok83) begin
                r_out_a <= r_side[ST_DSUM].neg[0] ^ r_side[ST_DSUM].neg[2]
                         ? -$signed({1'b0, r_cmag83[0]}) : $signed({1'b0, r_cmag83[0]});
                r_out_b <= r_side[ST_DSUM].neg[1] ^ r_side[ST_DSUM].neg[2]
                         ? -$signed({1'b0, r_cmag83[1]}) : $signed({1'b0, r_cmag83[1]});
                r_out_c <= r_cmag83[2];
                r_out_d <= w_dsat;
            end else begin
                r_out_a <= '0;
                r_out_b <= '0;
                r_out_c <= '0;
                r_out_d <= '0;
            end
        end
    end

    assign o_plane_valid    = r_out_ok;
    assign o_is_ceiling_out = r_side[ST_OUT].tag;
    assign o_coef_a         = r_out_a;
    assign o_coef_b         = r_out_b;
    assign o_coef_c         = r_out_c;
    assign o_coef_d         = r_out_d;

endmodule

FILE: src/tppf_checker.sv
`include "assert_macros.svh"

module tppf_checker import tppf_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic                   o_plane_valid,
    input logic signed [AB_W-1:0] o_coef_a,
    input logic signed [AB_W-1:0] o_coef_b,
    input logic [CF_W-1:0]        o_coef_c,
    input logic signed [PT_W-1:0] o_coef_d
);

    `AP_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_valid)

    `AP_IMPLY(a_bad_zero, i_clk, i_rst_n, o_valid && !o_plane_valid, (o_coef_a == 0) && (o_coef_b == 0) && (o_coef_c == 0) && (o_coef_d == 0))

    `AP_IMPLY(a_good_c, i_clk, i_rst_n, o_valid && o_plane_valid, (o_coef_c != 0) && (o_coef_a >= -65536) && (o_coef_a <= 65536))

    `AP_NEXT_RST(a_stall_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_coef_d))

endmodule

bind three_point_plane_fit_top tppf_checker u_tppf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_plane_valid (o_plane_valid),
    .o_coef_a      (o_coef_a),
    .o_coef_b      (o_coef_b),
    .o_coef_c      (o_coef_c),
    .o_coef_d      (o_coef_d)
);
